### rtl/stereo_volume_crystalizer_assert.svh
// Assertion macros for the stereo volume crystaliser.
`ifndef STEREO_VOLUME_CRYSTALIZER_ASSERT_SVH
`define STEREO_VOLUME_CRYSTALIZER_ASSERT_SVH

// antecedent holds, consequent holds in the same cycle
`define SVC_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// antecedent holds, consequent holds in the next cycle
`define SVC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/svc_pkg.sv
// Shared types, constants and helpers for the stereo volume crystaliser.
package svc_pkg;

  localparam int SampleW   = 16;
  localparam int GainW     = 11;
  localparam int StrengthW = 5;
  localparam int XgainW    = 10;
  localparam int CfgIdxW   = 2;

  localparam logic [GainW-1:0]     GainReset     = 11'd1024;
  localparam logic [StrengthW-1:0] StrengthReset = 5'd1;
  localparam logic [StrengthW-1:0] StrengthMin   = 5'd1;
  localparam logic [StrengthW-1:0] StrengthMax   = 5'd25;
  localparam logic [XgainW-1:0]    StrengthStep  = 10'd25;

  localparam logic signed [SampleW-1:0] SampleMax = 16'sh7FFF;
  localparam logic signed [SampleW-1:0] SampleMin = -16'sh8000;

  typedef enum logic [CfgIdxW-1:0] {
    REG_VOLUME_GAIN     = 2'd0,
    REG_EFFECT_ENABLE   = 2'd1,
    REG_EFFECT_STRENGTH = 2'd2,
    REG_UNUSED          = 2'd3
  } svc_reg_t;

  typedef struct packed {
    logic load;     // stage 1 takes a new sample
    logic commit;   // stage 1 item moves to output, prev updates
    logic present;  // stage 1 item is a real frame
  } svc_lane_ctl_t;

  function automatic logic signed [SampleW-1:0] sat16(input logic signed [20:0] x);
    logic signed [SampleW-1:0] r;
    if (x > 21'(SampleMax)) begin
      r = SampleMax;
    end else if (x < 21'(SampleMin)) begin
      r = SampleMin;
    end else begin
      r = x[SampleW-1:0];
    end
    return r;
  endfunction

  function automatic logic [XgainW-1:0] xgain_f(input logic en,
                                                 input logic [StrengthW-1:0] strength);
    logic [StrengthW-1:0] s;
    s = strength;
    if (s < StrengthMin) begin
      s = StrengthMin;
    end else if (s > StrengthMax) begin
      s = StrengthMax;
    end
    return en ? XgainW'(10'(s) * StrengthStep) : '0;
  endfunction

endpackage

### rtl/svc_lane.sv
// One channel lane: volume scaling, then first-difference enhancement.
module svc_lane (
  input  logic                                  clk,
  input  logic                                  rst,
  input  svc_pkg::svc_lane_ctl_t                ctl,
  input  logic signed [svc_pkg::SampleW-1:0]    sample,
  input  logic        [svc_pkg::GainW-1:0]      gain,
  input  logic        [svc_pkg::XgainW-1:0]     xgain,
  output logic signed [svc_pkg::SampleW-1:0]    res
);
  import svc_pkg::*;

  logic signed [27:0]        prod1;
  logic signed [SampleW-1:0] scaled_next;
  logic signed [SampleW-1:0] scaled;
  logic signed [SampleW-1:0] prev;
  logic signed [SampleW:0]   diff;
  logic signed [27:0]        prod2;
  logic signed [20:0]        sum;

  // stage 1: sample * gain / 1024, floor, saturate
  assign prod1       = 28'(sample) * 28'($signed({1'b0, gain}));
  assign scaled_next = sat16(21'($signed(prod1[27:10])));

  always_ff @(posedge clk) begin
    if (ctl.load) begin
      scaled <= scaled_next;
    end
  end

  // stage 2: add (scaled - prev) * xgain / 256, floor, saturate; zero when no frame is present
  assign diff  = 17'(scaled) - 17'(prev);
  assign prod2 = 28'(diff) * 28'($signed({1'b0, xgain}));
  assign sum   = 21'(scaled) + 21'($signed(prod2[27:8]));
  assign res   = ctl.present ? sat16(sum) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      prev <= '0;
    end else if (ctl.commit) begin
      prev <= ctl.present ? scaled : '0;
    end
  end

endmodule

### rtl/svc_merge.sv
// Output register joining both lanes into one stereo result.
module svc_merge (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  s1_valid,
  input  logic signed [svc_pkg::SampleW-1:0]    left_res,
  input  logic signed [svc_pkg::SampleW-1:0]    right_res,
  output logic                                  advance,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [svc_pkg::SampleW-1:0]    left_out,
  output logic signed [svc_pkg::SampleW-1:0]    right_out
);
  import svc_pkg::*;

  assign advance = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= s1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      left_out  <= left_res;
      right_out <= right_res;
    end
  end

endmodule

### rtl/stereo_volume_crystalizer.sv
// Top level of the stereo volume crystaliser: config, two lanes, output stage.
//
//   channel | direction | handshake            | payload
//   in      | input     | in_valid / in_ready  | left_in, right_in, frame_present
//   out     | output    | out_valid / out_ready| left_out, right_out
//   cfg     | input     | cfg_we               | cfg_index, cfg_data
//
// One frame per cycle while the output is not stalled.
// The path holds the scale register, then the output register after enhance and saturate.
// A stall on the output holds the whole pipeline; the input is refused meanwhile.
// Reset clears the config registers to defaults and both previous samples to zero.
module stereo_volume_crystalizer (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  logic signed [svc_pkg::SampleW-1:0]    left_in,
  input  logic signed [svc_pkg::SampleW-1:0]    right_in,
  input  logic                                  frame_present,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [svc_pkg::SampleW-1:0]    left_out,
  output logic signed [svc_pkg::SampleW-1:0]    right_out,
  input  logic                                  cfg_we,
  input  logic        [svc_pkg::CfgIdxW-1:0]    cfg_index,
  input  logic        [svc_pkg::GainW-1:0]      cfg_data
);
  import svc_pkg::*;
  `include "stereo_volume_crystalizer_assert.svh"

  logic [GainW-1:0]     volume_gain;
  logic                 effect_enable;
  logic [StrengthW-1:0] effect_strength;
  logic [XgainW-1:0]    xgain;

  logic                 advance;
  logic                 s1_valid;
  logic                 s1_present;
  svc_lane_ctl_t        lane_ctl;
  logic signed [SampleW-1:0] left_res;
  logic signed [SampleW-1:0] right_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      volume_gain     <= GainReset;
      effect_enable   <= 1'b0;
      effect_strength <= StrengthReset;
    end else if (cfg_we) begin
      case (svc_reg_t'(cfg_index))
        REG_VOLUME_GAIN:     volume_gain     <= cfg_data;
        REG_EFFECT_ENABLE:   effect_enable   <= cfg_data[0];
        REG_EFFECT_STRENGTH: effect_strength <= cfg_data[StrengthW-1:0];
        default: ;
      endcase
    end
  end

  assign xgain    = xgain_f(effect_enable, effect_strength);
  assign in_ready = advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid   <= 1'b0;
      s1_present <= 1'b0;
    end else if (advance) begin
      s1_valid   <= in_valid;
      s1_present <= frame_present;
    end
  end

  always_comb begin
    lane_ctl.load    = advance;
    lane_ctl.commit  = advance && s1_valid;
    lane_ctl.present = s1_present;
  end

  svc_lane u_lane_left (
    .clk    (clk),
    .rst    (rst),
    .ctl    (lane_ctl),
    .sample (left_in),
    .gain   (volume_gain),
    .xgain  (xgain),
    .res    (left_res)
  );

  svc_lane u_lane_right (
    .clk    (clk),
    .rst    (rst),
    .ctl    (lane_ctl),
    .sample (right_in),
    .gain   (volume_gain),
    .xgain  (xgain),
    .res    (right_res)
  );

  svc_merge u_merge (
    .clk       (clk),
    .rst       (rst),
    .s1_valid  (s1_valid),
    .left_res  (left_res),
    .right_res (right_res),
    .advance   (advance),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .left_out  (left_out),
    .right_out (right_out)
  );

  `SVC_ASSERT_NEXT(a_underrun_silent, advance && s1_valid && !s1_present,
                   out_valid && left_out == '0 && right_out == '0,
                   "underrun frame gave non-silent output")
  `SVC_ASSERT_NEXT(a_no_phantom, advance && !s1_valid, !out_valid,
                   "result produced without a frame")
  `SVC_ASSERT_NEXT(a_frame_reaches_s1, in_valid && in_ready, s1_valid,
                   "accepted frame lost before lane stage")

endmodule
